// ===== hdl/dpf_pkg.sv =====
package dpf_pkg;

  localparam int unsigned MAX_CLASSES = 255;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_CONF_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_LEFT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_TOP        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RATIO_X        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RATIO_Y        = 3'd5;

  typedef struct packed {
    logic signed [31:0] tensor_value;
    logic               frame_start;
  } dpf_in_t;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_width;
    logic signed [15:0] box_height;
    logic [7:0]         class_index;
    logic [16:0]        box_score;
    logic [15:0]        proposal_index;
  } dpf_out_t;

  typedef struct packed {
    logic [16:0] conf_threshold;
    logic [7:0]  class_count;
    logic [11:0] pad_left;
    logic [11:0] pad_top;
    logic [23:0] ratio_x;
    logic [23:0] ratio_y;
  } dpf_cfg_t;

  // Finished row handed from the front to the back.
  // xl/yt are doubled left/top edges (Q.17) so the half width stays exact.
  typedef struct packed {
    logic signed [34:0] xl;
    logic signed [34:0] yt;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic               obj_ok;
    logic [30:0]        obj;
    logic [30:0]        best;
    logic [7:0]         cls;
    logic [15:0]        prop;
  } dpf_row_t;

  // Shift right with truncation toward zero, then saturate to 16 bits signed.
  function automatic logic signed [15:0] pix_sat(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic signed [63:0] bias;
    logic signed [63:0] q;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    q    = (v + bias) >>> sh;
    if (q > 64'sd32767) begin
      pix_sat = 16'sh7fff;
    end else if (q < -64'sd32768) begin
      pix_sat = 16'sh8000;
    end else begin
      pix_sat = q[15:0];
    end
  endfunction

endpackage

// ===== hdl/dpf_front.sv =====
module dpf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  dpf_pkg::dpf_in_t  item,
  input  dpf_pkg::dpf_cfg_t cfg,
  output logic              push,
  output dpf_pkg::dpf_row_t row
);
  import dpf_pkg::*;

  logic [8:0]         pos,  pos_e;
  logic [15:0]        prop, prop_e;
  logic signed [31:0] cx, cy, w, h, obj, best;
  logic [7:0]         cls;

  logic signed [31:0] cx_u, cy_u, w_u, h_u, obj_u, best_u;
  logic [7:0]         cls_u;
  logic [7:0]         nc;
  logic               row_end;
  logic signed [31:0] v;

  assign v  = item.tensor_value;
  assign nc = (cfg.class_count > 8'(MAX_CLASSES)) ? 8'(MAX_CLASSES) : cfg.class_count;

  always_comb begin
    // frame start drops any partial row and restarts the row count
    pos_e  = item.frame_start ? 9'd0  : pos;
    prop_e = item.frame_start ? 16'd0 : prop;
    cx_u   = item.frame_start ? 32'sd0 : cx;
    cy_u   = item.frame_start ? 32'sd0 : cy;
    w_u    = item.frame_start ? 32'sd0 : w;
    h_u    = item.frame_start ? 32'sd0 : h;
    obj_u  = item.frame_start ? 32'sd0 : obj;
    best_u = item.frame_start ? 32'sd0 : best;
    cls_u  = item.frame_start ? 8'd0  : cls;
    unique case (pos_e)
      9'd0: cx_u  = v;
      9'd1: cy_u  = v;
      9'd2: w_u   = v;
      9'd3: h_u   = v;
      9'd4: obj_u = v;
      default: begin
        if (v > best_u) begin
          best_u = v;
          cls_u  = 8'(pos_e - 9'd5);
        end
      end
    endcase
    row_end = {1'b0, pos_e} >= (10'd4 + 10'(nc));

    row.xl     = (35'(cx_u) <<< 1) - $signed(35'({cfg.pad_left, 17'd0})) - 35'(w_u);
    row.yt     = (35'(cy_u) <<< 1) - $signed(35'({cfg.pad_top, 17'd0})) - 35'(h_u);
    row.w      = w_u;
    row.h      = h_u;
    row.obj_ok = obj_u > $signed({15'd0, cfg.conf_threshold});
    row.obj    = obj_u[30:0];
    row.best   = best_u[30:0];
    row.cls    = cls_u;
    row.prop   = prop_e;
  end

  assign push = accept && row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      prop <= '0;
      cx   <= '0;
      cy   <= '0;
      w    <= '0;
      h    <= '0;
      obj  <= '0;
      best <= '0;
      cls  <= '0;
    end else if (accept) begin
      if (row_end) begin
        pos  <= '0;
        prop <= prop_e + 16'd1;
        cx   <= '0;
        cy   <= '0;
        w    <= '0;
        h    <= '0;
        obj  <= '0;
        best <= '0;
        cls  <= '0;
      end else begin
        pos  <= pos_e + 9'd1;
        prop <= prop_e;
        cx   <= cx_u;
        cy   <= cy_u;
        w    <= w_u;
        h    <= h_u;
        obj  <= obj_u;
        best <= best_u;
        cls  <= cls_u;
      end
    end
  end

endmodule

// ===== hdl/dpf_queue.sv =====
module dpf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dpf_pkg::dpf_row_t push_data,
  input  logic              pop,
  output dpf_pkg::dpf_row_t pop_data,
  output logic              not_empty,
  output logic              full
);
  import dpf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dpf_row_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign not_empty = count != '0;
  assign full      = count == CNT_W'(DEPTH);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/dpf_back.sv =====
module dpf_back (
  input  logic              clk,
  input  logic              rst,
  input  dpf_pkg::dpf_cfg_t cfg,
  input  logic              row_valid,
  input  dpf_pkg::dpf_row_t row,
  output logic              pop,
  output logic              box_valid,
  input  logic              box_ready,
  output dpf_pkg::dpf_out_t box
);
  import dpf_pkg::*;

  // product stage
  logic               s1_valid;
  logic               s1_ok;
  logic [61:0]        s1_prod;
  logic signed [59:0] s1_px, s1_py;
  logic signed [55:0] s1_pw, s1_ph;
  logic [7:0]         s1_cls;
  logic [15:0]        s1_prop;

  logic               pass, s1_move, load;
  logic signed [24:0] rx, ry;

  assign rx = $signed({1'b0, cfg.ratio_x});
  assign ry = $signed({1'b0, cfg.ratio_y});

  assign pass    = s1_ok && (s1_prod > {29'd0, cfg.conf_threshold, 16'd0});
  // failing rows drop out without waiting on the output register
  assign s1_move = s1_valid && (!pass || !box_valid || box_ready);
  assign load    = s1_move && pass;
  assign pop     = row_valid && (!s1_valid || s1_move);

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ok   <= row.obj_ok;
      s1_prod <= 62'(row.obj) * 62'(row.best);
      s1_px   <= 60'(row.xl) * 60'(rx);
      s1_py   <= 60'(row.yt) * 60'(ry);
      s1_pw   <= 56'(row.w) * 56'(rx);
      s1_ph   <= 56'(row.h) * 56'(ry);
      s1_cls  <= row.cls;
      s1_prop <= row.prop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      box.box_left       <= pix_sat(64'(s1_px), 33);
      box.box_top        <= pix_sat(64'(s1_py), 33);
      box.box_width      <= pix_sat(64'(s1_pw), 32);
      box.box_height     <= pix_sat(64'(s1_ph), 32);
      box.class_index    <= s1_cls;
      box.box_score      <= (s1_prod[61:16] > 46'd65536) ? 17'd65536 : s1_prod[32:16];
      box.proposal_index <= s1_prop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      box_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (load) begin
        box_valid <= 1'b1;
      end else if (box_ready) begin
        box_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/detection_proposal_filter.sv =====
// Detection proposal filter: decodes a detector's output tensor into boxes.
// Tensor channel (tensor_valid/tensor_ready/tensor): one signed Q16.16 value
// per transfer, rows of five header values then a configurable number of
// class scores; frame_start marks the first value of a frame.
// Box channel (box_valid/box_ready/box): at most one box per row, emitted
// when objectness and best score times objectness both exceed conf_threshold.
// Throughput: one tensor value per cycle while tensor_ready is high. The front
// tracks the row and arg-max as values arrive; completed rows go through a
// QUEUE_DEPTH entry queue into a two-stage back end (multipliers, then
// scale/saturate); a row's box passes the queue, then both back-end stages.
// A stalled box channel first fills the output register, then the product
// stage, then the queue; tensor_ready drops only when the queue is full.
// Rows that fail the thresholds never occupy the output register.
// Configuration: cfg_we/cfg_index/cfg_data, written only while the block is
// idle, a user rule the block does not enforce; reset loads threshold 0.25,
// 80 classes, no padding, unit ratios. Reset (rst, synchronous) empties the
// queue and pipeline and restarts the row and proposal counters.
module detection_proposal_filter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tensor_valid,
  output logic                                tensor_ready,
  input  dpf_pkg::dpf_in_t                    tensor,
  output logic                                box_valid,
  input  logic                                box_ready,
  output dpf_pkg::dpf_out_t                   box,
  input  logic                                cfg_we,
  input  logic [dpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dpf_pkg::*;

  dpf_cfg_t cfg;
  dpf_row_t push_row, pop_row;
  logic     push, pop, q_not_empty, q_full, accept;

  assign tensor_ready = !q_full;
  assign accept       = tensor_valid && tensor_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= 17'd16384;
      cfg.class_count    <= 8'd80;
      cfg.pad_left       <= 12'd0;
      cfg.pad_top        <= 12'd0;
      cfg.ratio_x        <= 24'd65536;
      cfg.ratio_y        <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONF_THRESHOLD: cfg.conf_threshold <= cfg_data[16:0];
        REG_CLASS_COUNT:    cfg.class_count    <= cfg_data[7:0];
        REG_PAD_LEFT:       cfg.pad_left       <= cfg_data[11:0];
        REG_PAD_TOP:        cfg.pad_top        <= cfg_data[11:0];
        REG_RATIO_X:        cfg.ratio_x        <= cfg_data[23:0];
        REG_RATIO_Y:        cfg.ratio_y        <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  dpf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (tensor),
    .cfg    (cfg),
    .push   (push),
    .row    (push_row)
  );

  dpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_row),
    .pop       (pop),
    .pop_data  (pop_row),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  dpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .row_valid (q_not_empty),
    .row       (pop_row),
    .pop       (pop),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box)
  );

endmodule

// ===== hdl/dpf_checker.sv =====
module dpf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            tensor_valid,
  input logic                            tensor_ready,
  input dpf_pkg::dpf_in_t                tensor,
  input logic                            box_valid,
  input logic                            box_ready,
  input dpf_pkg::dpf_out_t               box,
  input logic                            cfg_we,
  input logic [dpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [dpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dpf_pkg::*;

  // a stalled box holds its value
  a_box_hold: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_ready |=> box_valid && $stable(box))
    else $error("box changed while stalled");

  // reset leaves no box pending and the tensor side open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !box_valid && tensor_ready)
    else $error("pipeline not empty after reset");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> box.box_score <= 17'd65536)
    else $error("box score above saturation limit");

  // a row holds at most 255 class scores
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> box.class_index != 8'hff)
    else $error("class index out of range");

endmodule

bind detection_proposal_filter dpf_checker u_dpf_checker (.*);
